FILE: rtl/secm_pkg.sv
// ----------------------------------------------------------------------------
// secm_pkg
// Shared widths, register indexes and reset values for the stereo envelope
// and crest meter.
// ----------------------------------------------------------------------------
package secm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int LOG_W    = 20;
	localparam int MUL_W    = 20;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RMS_ATTACK   = 3'd0,
		REG_RMS_RELEASE  = 3'd1,
		REG_PEAK_ATTACK  = 3'd2,
		REG_PEAK_RELEASE = 3'd3,
		REG_MONO_MODE    = 3'd4
	} reg_idx_t;

	typedef enum logic {
		FUNC_PROCESS = 1'b0,
		FUNC_CLEAR   = 1'b1
	} func_t;

	localparam logic [COEF_W-1:0] RMS_ATTACK_RST   = 16'd65400;
	localparam logic [COEF_W-1:0] RMS_RELEASE_RST  = 16'd65522;
	localparam logic [COEF_W-1:0] PEAK_ATTACK_RST  = 16'd65264;
	localparam logic [COEF_W-1:0] PEAK_RELEASE_RST = 16'd65509;

	// 20*log10(2) in Q16
	localparam logic [MUL_W-1:0] CREST_K = 20'd394566;

endpackage

FILE: rtl/secm_if.sv
// ----------------------------------------------------------------------------
// secm_frame_if / secm_result_if
// Valid/ready channels for input frames and meter results.
// ----------------------------------------------------------------------------
interface secm_frame_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic signed [secm_pkg::SAMPLE_W-1:0] left_sample;
	logic signed [secm_pkg::SAMPLE_W-1:0] right_sample;
	logic        end_of_block;

	modport source (output valid, func, left_sample, right_sample, end_of_block, input ready);
	modport sink (input valid, func, left_sample, right_sample, end_of_block, output ready);
endinterface

interface secm_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] rms_left;
	logic [15:0] rms_right;
	logic [15:0] peak_left;
	logic [15:0] peak_right;
	logic signed [15:0] crest_left_db;
	logic signed [15:0] crest_right_db;
	logic        block_done;

	modport source (output valid, rms_left, rms_right, peak_left, peak_right,
		crest_left_db, crest_right_db, block_done, input ready);
	modport sink (input valid, rms_left, rms_right, peak_left, peak_right,
		crest_left_db, crest_right_db, block_done, output ready);
endinterface

FILE: rtl/secm_mul.sv
// ----------------------------------------------------------------------------
// secm_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module secm_mul (
	input  logic                              clk,
	input  logic [secm_pkg::MUL_W-1:0]        a,
	input  logic [secm_pkg::MUL_W-1:0]        b,
	output logic [2*secm_pkg::MUL_W-1:0]      p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

FILE: rtl/stereo_envelope_crest_meter_top.sv
// ----------------------------------------------------------------------------
// stereo_envelope_crest_meter_top
// A frame passes the follower, log2 and crest states before its result is valid;
// a clear sets its result from idle. One shared multiplier runs 4 follower
// updates, 4 log2 evaluations (an init step and 16 squarings each) and 2 crest
// scalings in turn. Frames are taken only in idle and when no result is left untaken.
// Reset: coefficients go to their package defaults, envelopes to zero, no result.
// ----------------------------------------------------------------------------
module stereo_envelope_crest_meter_top (
	input  logic                 clk,
	input  logic                 arst_n,
	secm_frame_if.sink           frame,
	secm_result_if.source        result,
	input  logic                 cfg_we,
	input  logic [secm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [secm_pkg::COEF_W-1:0]    cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_FOL, ST_LOG_INIT, ST_LOG, ST_CREST
	} state_t;

	state_t state_q;
	logic [1:0]  idx_q;
	logic [3:0]  it_q;
	logic        ph_q;
	logic        res_valid_q;

	logic [15:0] rms_att_q, rms_rel_q, peak_att_q, peak_rel_q;
	logic        mono_q;

	logic [15:0] env_q [4];
	logic [secm_pkg::LOG_W-1:0] log_q [4];
	logic [15:0] crest_q [2];
	logic [16:0] m_q;
	logic [3:0]  e_q;
	logic [14:0] f_q;

	logic [15:0] xl_q, xr_q;
	logic        done_q;

	logic [secm_pkg::MUL_W-1:0]   mul_a, mul_b;
	logic [2*secm_pkg::MUL_W-1:0] mul_p;

	logic        accept;
	logic [15:0] cur_env, cur_x, coef, diff, fol_new;
	logic        up;
	logic [39:0] p_round;
	logic [3:0]  lead;
	logic [31:0] m_shift;
	logic [17:0] sq;
	logic [16:0] m_next;
	logic        f_bit;
	logic [20:0] ld;
	logic        neg;
	logic [19:0] mag;
	logic [39:0] q_round;
	logic [15:0] q;
	logic [15:0] crest_val;
	logic        zero;
	logic [15:0] in_xl, in_xr;

	secm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	assign accept      = frame.valid && frame.ready;
	assign frame.ready = (state_q == ST_IDLE) && (!res_valid_q || result.ready);

	assign in_xl = frame.left_sample[15] ? 16'(-frame.left_sample) : frame.left_sample;
	assign in_xr = mono_q ? in_xl :
		(frame.right_sample[15] ? 16'(-frame.right_sample) : frame.right_sample);

	always_comb begin
		cur_env = env_q[idx_q];
		cur_x   = idx_q[0] ? xr_q : xl_q;
		up      = cur_x > cur_env;
		if (idx_q[1])
			coef = up ? peak_att_q : peak_rel_q;
		else
			coef = up ? rms_att_q : rms_rel_q;
		diff    = up ? cur_x - cur_env : cur_env - cur_x;
		// attack rounds the decrement up, release floors the increment
		p_round = mul_p + 40'd65535;
		fol_new = up ? cur_x - p_round[31:16] : cur_x + mul_p[31:16];

		lead = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (cur_env[i])
				lead = 4'(i);
		end
		m_shift = {cur_env, 16'b0} >> lead;

		sq     = mul_p[33:16];
		f_bit  = sq[17];
		m_next = f_bit ? sq[17:1] : sq[16:0];

		ld   = {1'b0, log_q[{1'b1, idx_q[0]}]} - {1'b0, log_q[{1'b0, idx_q[0]}]};
		neg  = ld[20];
		mag  = neg ? 20'(-ld) : ld[19:0];
		q_round = mul_p + (40'd1 << 23);
		q    = q_round[39:24];
		if (neg)
			crest_val = q[15] ? 16'h8000 : 16'(-q);
		else
			crest_val = q[15] ? 16'h7fff : q;
		zero = (env_q[{1'b1, idx_q[0]}] == 16'd0) || (env_q[{1'b0, idx_q[0]}] == 16'd0);

		case (state_q)
			ST_FOL: begin
				mul_a = {4'b0, diff};
				mul_b = {4'b0, coef};
			end
			ST_LOG: begin
				mul_a = {3'b0, m_q};
				mul_b = {3'b0, m_q};
			end
			ST_CREST: begin
				mul_a = mag;
				mul_b = secm_pkg::CREST_K;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// sample payload, captured on frame transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			xl_q   <= in_xl;
			xr_q   <= in_xr;
			done_q <= frame.end_of_block;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			it_q        <= '0;
			ph_q        <= 1'b0;
			res_valid_q <= 1'b0;
			rms_att_q   <= secm_pkg::RMS_ATTACK_RST;
			rms_rel_q   <= secm_pkg::RMS_RELEASE_RST;
			peak_att_q  <= secm_pkg::PEAK_ATTACK_RST;
			peak_rel_q  <= secm_pkg::PEAK_RELEASE_RST;
			mono_q      <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				env_q[i] <= '0;
				log_q[i] <= '0;
			end
			crest_q[0]  <= '0;
			crest_q[1]  <= '0;
			m_q         <= '0;
			e_q         <= '0;
			f_q         <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					secm_pkg::REG_RMS_ATTACK:   rms_att_q  <= cfg_data;
					secm_pkg::REG_RMS_RELEASE:  rms_rel_q  <= cfg_data;
					secm_pkg::REG_PEAK_ATTACK:  peak_att_q <= cfg_data;
					secm_pkg::REG_PEAK_RELEASE: peak_rel_q <= cfg_data;
					secm_pkg::REG_MONO_MODE:    mono_q     <= cfg_data[0];
					default: ;
				endcase
			end

			// a frame transfer settles the result flag in the idle arm
			if (result.valid && result.ready && !accept)
				res_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						ph_q  <= 1'b0;
						if (frame.func == secm_pkg::FUNC_CLEAR) begin
							for (int i = 0; i < 4; i++)
								env_q[i] <= '0;
							crest_q[0]  <= '0;
							crest_q[1]  <= '0;
							res_valid_q <= 1'b1;
						end else begin
							res_valid_q <= 1'b0;
							state_q     <= ST_FOL;
						end
					end
				end
				ST_FOL: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						env_q[idx_q] <= fol_new;
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3)
							state_q <= ST_LOG_INIT;
					end
				end
				ST_LOG_INIT: begin
					m_q     <= m_shift[16:0];
					e_q     <= lead;
					f_q     <= '0;
					it_q    <= '0;
					ph_q    <= 1'b0;
					state_q <= ST_LOG;
				end
				ST_LOG: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						m_q  <= m_next;
						f_q  <= {f_q[13:0], f_bit};
						it_q <= it_q + 4'd1;
						if (it_q == 4'd15) begin
							log_q[idx_q] <= {e_q, f_q, f_bit};
							idx_q <= idx_q + 2'd1;
							state_q <= (idx_q == 2'd3) ? ST_CREST : ST_LOG_INIT;
						end
					end
				end
				ST_CREST: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						crest_q[idx_q[0]] <= zero ? 16'd0 : crest_val;
						idx_q <= idx_q + 2'd1;
						if (idx_q[0]) begin
							res_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid          = res_valid_q;
	assign result.rms_left       = env_q[0];
	assign result.rms_right      = env_q[1];
	assign result.peak_left      = env_q[2];
	assign result.peak_right     = env_q[3];
	assign result.crest_left_db  = crest_q[0];
	assign result.crest_right_db = crest_q[1];
	assign result.block_done     = done_q;

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stereo envelope and crest meter. A bit-exact
// envelope/crest predictor runs on every accepted frame, and the result
// monitor checks each result field against the oldest prediction. Coefficient
// and mono settings are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

	typedef logic [secm_pkg::CFG_IDX_W-1:0] cfg_idx_t;

	typedef struct {
		secm_pkg::func_t    func;
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               eob;
	} frame_t;

	typedef struct {
		logic [15:0] rms_l;
		logic [15:0] rms_r;
		logic [15:0] peak_l;
		logic [15:0] peak_r;
		logic [15:0] crest_l;
		logic [15:0] crest_r;
		logic        done;
	} meter_t;

	localparam int CYCLE_LIMIT = 10000000;
	localparam int DRAIN_CYCLES = 200;

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_idx;
	logic [secm_pkg::COEF_W-1:0] cfg_data;

	secm_frame_if  frame_ch();
	secm_result_if result_ch();

	stereo_envelope_crest_meter_top DUT (
		.clk(clk), .arst_n(arst_n), .frame(frame_ch.sink), .result(result_ch.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	frame_t frame_q[$];
	meter_t meter_q[$];
	int     n_errors = 0;
	int     cycles = 0;
	bit     tx_steady = 0;
	bit     rx_steady = 0;
	int     rx_long_req = 0;

	// predictor state
	int unsigned coef_rms_att, coef_rms_rel, coef_pk_att, coef_pk_rel;
	bit          mono;
	int unsigned env_rms_l, env_rms_r, env_pk_l, env_pk_r;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int unsigned magnitude(logic signed [15:0] s);
		if (s[15])
			return 65536 - int'({16'd0, s});
		return int'({16'd0, s});
	endfunction

	function automatic int unsigned track(int unsigned env, int unsigned x,
			int unsigned att, int unsigned rel);
		longint unsigned prod;
		if (x > env) begin
			prod = longint'(x - env) * att;
			return x - int'((prod + 65535) >> 16);
		end
		prod = longint'(env - x) * rel;
		return x + int'(prod >> 16);
	endfunction

	function automatic longint log2_fix(int unsigned v);
		int unsigned e, t, f;
		longint unsigned m;
		e = 0;
		t = v;
		f = 0;
		while (t > 1) begin
			t = t >> 1;
			e++;
		end
		m = (longint'(v) << 16) >> e;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 16;
			f = f << 1;
			if (m >= 131072) begin
				m = m >> 1;
				f = f | 1;
			end
		end
		return longint'(e) * 65536 + f;
	endfunction

	function automatic logic [15:0] crest_q8(int unsigned pk, int unsigned rms);
		longint diff, val;
		longint unsigned mag, q;
		if (pk == 0 || rms == 0)
			return 16'd0;
		diff = log2_fix(pk) - log2_fix(rms);
		mag = longint'(diff < 0 ? -diff : diff) * longint'(secm_pkg::CREST_K);
		q = (mag + (64'd1 << 23)) >> 24;
		if (q > 40000)
			q = 40000;
		val = diff < 0 ? -longint'(q) : longint'(q);
		if (val > 32767)
			val = 32767;
		if (val < -32768)
			val = -32768;
		return val[15:0];
	endfunction

	function automatic meter_t meter_predict(frame_t f);
		meter_t r;
		int unsigned xl, xr;
		if (f.func == secm_pkg::FUNC_CLEAR) begin
			env_rms_l = 0;
			env_rms_r = 0;
			env_pk_l = 0;
			env_pk_r = 0;
		end else begin
			xl = magnitude(f.left);
			xr = mono ? xl : magnitude(f.right);
			env_rms_l = track(env_rms_l, xl, coef_rms_att, coef_rms_rel);
			env_rms_r = track(env_rms_r, xr, coef_rms_att, coef_rms_rel);
			env_pk_l = track(env_pk_l, xl, coef_pk_att, coef_pk_rel);
			env_pk_r = track(env_pk_r, xr, coef_pk_att, coef_pk_rel);
		end
		r.rms_l = env_rms_l[15:0];
		r.rms_r = env_rms_r[15:0];
		r.peak_l = env_pk_l[15:0];
		r.peak_r = env_pk_r[15:0];
		r.crest_l = crest_q8(env_pk_l, env_rms_l);
		r.crest_r = crest_q8(env_pk_r, env_rms_r);
		r.done = f.eob;
		return r;
	endfunction

	// frame driver
	int tx_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		frame_t cur;
		int r;
		if (!arst_n) begin
			frame_ch.valid <= 0;
			frame_ch.func <= secm_pkg::FUNC_PROCESS;
			frame_ch.left_sample <= '0;
			frame_ch.right_sample <= '0;
			frame_ch.end_of_block <= 0;
			tx_gap = 0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				cur.func = secm_pkg::func_t'(frame_ch.func);
				cur.left = frame_ch.left_sample;
				cur.right = frame_ch.right_sample;
				cur.eob = frame_ch.end_of_block;
				meter_q.push_back(meter_predict(cur));
				void'(frame_q.pop_front());
				if (!tx_steady) begin
					r = $urandom_range(99);
					tx_gap = r < 70 ? 0 : r < 95 ? $urandom_range(1, 5)
						: $urandom_range(50, 400);
				end
			end
			if (tx_gap > 0) begin
				tx_gap--;
				frame_ch.valid <= 0;
			end else if (frame_q.size() > 0) begin
				frame_ch.valid <= 1;
				frame_ch.func <= frame_q[0].func;
				frame_ch.left_sample <= frame_q[0].left;
				frame_ch.right_sample <= frame_q[0].right;
				frame_ch.end_of_block <= frame_q[0].eob;
			end else begin
				frame_ch.valid <= 0;
			end
		end
	end

	// result monitor
	int rx_hold = 0;
	int rx_long_done = 0;
	always @(posedge clk or negedge arst_n) begin
		meter_t e;
		int r;
		if (!arst_n) begin
			result_ch.ready <= 0;
			rx_hold = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (meter_q.size() == 0) begin
					$error("unexpected result transfer");
					n_errors++;
				end else begin
					e = meter_q.pop_front();
					if (result_ch.rms_left !== e.rms_l) begin
						$error("rms_left exp %0d got %0d", e.rms_l, result_ch.rms_left);
						n_errors++;
					end
					if (result_ch.rms_right !== e.rms_r) begin
						$error("rms_right exp %0d got %0d", e.rms_r, result_ch.rms_right);
						n_errors++;
					end
					if (result_ch.peak_left !== e.peak_l) begin
						$error("peak_left exp %0d got %0d", e.peak_l, result_ch.peak_left);
						n_errors++;
					end
					if (result_ch.peak_right !== e.peak_r) begin
						$error("peak_right exp %0d got %0d", e.peak_r, result_ch.peak_right);
						n_errors++;
					end
					if (result_ch.crest_left_db !== e.crest_l) begin
						$error("crest_left_db exp %0d got %0d", $signed(e.crest_l),
							result_ch.crest_left_db);
						n_errors++;
					end
					if (result_ch.crest_right_db !== e.crest_r) begin
						$error("crest_right_db exp %0d got %0d", $signed(e.crest_r),
							result_ch.crest_right_db);
						n_errors++;
					end
					if (result_ch.block_done !== e.done) begin
						$error("block_done exp %0d got %0d", e.done, result_ch.block_done);
						n_errors++;
					end
				end
			end
			if (rx_long_done < rx_long_req) begin
				// long hold so the block backs up and stalls frame input
				rx_long_done++;
				rx_hold = 3000;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				result_ch.ready <= 0;
			end else begin
				result_ch.ready <= 1;
				if (!rx_steady) begin
					r = $urandom_range(99);
					rx_hold = r < 70 ? 0 : r < 95 ? $urandom_range(1, 4)
						: $urandom_range(30, 300);
				end
			end
		end
	end

	task automatic reg_write(secm_pkg::reg_idx_t idx, logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= data;
		case (idx)
			secm_pkg::REG_RMS_ATTACK:   coef_rms_att = 32'(data);
			secm_pkg::REG_RMS_RELEASE:  coef_rms_rel = 32'(data);
			secm_pkg::REG_PEAK_ATTACK:  coef_pk_att = 32'(data);
			secm_pkg::REG_PEAK_RELEASE: coef_pk_rel = 32'(data);
			secm_pkg::REG_MONO_MODE:    mono = data[0];
			default: ;
		endcase
	endtask

	task automatic set_all(logic [15:0] ra, logic [15:0] rr, logic [15:0] pa,
			logic [15:0] pr, bit m);
		reg_write(secm_pkg::REG_RMS_ATTACK, ra);
		reg_write(secm_pkg::REG_RMS_RELEASE, rr);
		reg_write(secm_pkg::REG_PEAK_ATTACK, pa);
		reg_write(secm_pkg::REG_PEAK_RELEASE, pr);
		reg_write(secm_pkg::REG_MONO_MODE, {15'd0, m});
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic push(secm_pkg::func_t fn, int l, int rt, bit eob);
		frame_t f;
		f.func = fn;
		f.left = l[15:0];
		f.right = rt[15:0];
		f.eob = eob;
		frame_q.push_back(f);
	endtask

	task automatic settle();
		wait (frame_q.size() == 0 && meter_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int rand_sample(int style);
		case (style)
			0: return $urandom_range(0, 65535);
			1: return $urandom_range(0, 255) - 128;
			2: return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 7)
				: -32768 + $urandom_range(0, 7);
			default: return ($urandom_range(0, 65535) >> $urandom_range(0, 15))
				* ($urandom_range(0, 1) ? 1 : -1);
		endcase
	endfunction

	task automatic random_frames(int n);
		int style, l;
		for (int i = 0; i < n; i++) begin
			style = $urandom_range(0, 3);
			if ($urandom_range(99) < 4) begin
				push(secm_pkg::FUNC_CLEAR, $urandom_range(0, 65535),
					$urandom_range(0, 65535), 1'($urandom_range(0, 1)));
			end else begin
				l = rand_sample(style);
				push(secm_pkg::FUNC_PROCESS, l,
					$urandom_range(0, 3) == 0 ? l : rand_sample(style),
					(i % 16) == 15 || $urandom_range(99) < 3);
			end
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = '0;
		cfg_data = '0;
		coef_rms_att = 32'(secm_pkg::RMS_ATTACK_RST);
		coef_rms_rel = 32'(secm_pkg::RMS_RELEASE_RST);
		coef_pk_att = 32'(secm_pkg::PEAK_ATTACK_RST);
		coef_pk_rel = 32'(secm_pkg::PEAK_RELEASE_RST);
		mono = 0;
		env_rms_l = 0;
		env_rms_r = 0;
		env_pk_l = 0;
		env_pk_r = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset defaults, extremes, clear, mono
		tx_steady = 1;
		rx_steady = 1;
		push(secm_pkg::FUNC_PROCESS, 0, 0, 0);
		push(secm_pkg::FUNC_PROCESS, -32768, 32767, 0);
		push(secm_pkg::FUNC_PROCESS, 32767, -32768, 0);
		push(secm_pkg::FUNC_PROCESS, -1, 1, 0);
		push(secm_pkg::FUNC_PROCESS, 0, 0, 1);
		push(secm_pkg::FUNC_CLEAR, -32768, 32767, 1);
		push(secm_pkg::FUNC_PROCESS, 1, -1, 0);
		push(secm_pkg::FUNC_PROCESS, -32768, -32768, 0);
		push(secm_pkg::FUNC_CLEAR, 0, 0, 0);
		settle();
		set_all(16'd0, 16'd0, 16'd0, 16'd0, 1);
		push(secm_pkg::FUNC_PROCESS, -32768, 5, 0);
		push(secm_pkg::FUNC_PROCESS, 100, 32767, 0);
		push(secm_pkg::FUNC_PROCESS, 0, -32768, 1);
		settle();
		set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
		push(secm_pkg::FUNC_PROCESS, -32768, 32767, 0);
		push(secm_pkg::FUNC_PROCESS, 0, 0, 0);
		push(secm_pkg::FUNC_PROCESS, 12345, -23456, 1);
		settle();
		// writes above the last register index do nothing
		for (int k = 1; k <= 3; k++) begin
			@(posedge clk);
			cfg_we <= 1;
			cfg_idx <= cfg_idx_t'(secm_pkg::REG_MONO_MODE + k);
			cfg_data <= 16'hFFFF;
		end
		@(posedge clk);
		cfg_we <= 0;
		push(secm_pkg::FUNC_PROCESS, 32767, 1, 0);
		push(secm_pkg::FUNC_PROCESS, -7, 300, 1);
		settle();
		tx_steady = 0;
		rx_steady = 0;

		// random phases across coefficient settings
		set_all(secm_pkg::RMS_ATTACK_RST, secm_pkg::RMS_RELEASE_RST,
			secm_pkg::PEAK_ATTACK_RST, secm_pkg::PEAK_RELEASE_RST, 0);
		rx_long_req = 1;
		random_frames(250);
		settle();
		set_all(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1);
		random_frames(200);
		settle();
		set_all(16'd30000, 16'd60000, 16'd1000, 16'd40000, 0);
		tx_steady = 1;
		rx_steady = 1;
		random_frames(150);
		settle();
		tx_steady = 0;
		rx_steady = 0;
		for (int p = 0; p < 5; p++) begin
			set_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				1'($urandom_range(0, 1)));
			random_frames(180);
			if (p == 2)
				rx_long_req = 2;
			settle();
		end
		set_all(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 0);
		random_frames(100);
		settle();

		if (n_errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
